// ===== rtl/archive_stream_deframer_core_assert.svh =====
// Assertion macros for the archive stream deframer.
// They expect clk and rst in the scope where they are used.
`ifndef ARCHIVE_STREAM_DEFRAMER_CORE_ASSERT_SVH
`define ARCHIVE_STREAM_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ASD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/asd_pkg.sv =====
// Package for the archive stream deframer: sizes, phase and kind codes,
// and the result item type. No dependencies.
`default_nettype none

package asd_pkg;

  // Header bytes skipped before the version
  localparam int unsigned HEADER_SKIP = 13;
  // Width of the size accumulator and the field byte counter
  localparam int unsigned SIZE_WIDTH  = 32;
  localparam int unsigned CNT_W       = SIZE_WIDTH;

  localparam logic [7:0] REC_FILE   = 8'h00;
  localparam logic [7:0] REC_MARKER = 8'hFF;
  localparam logic [2:0] META_LAST  = 3'd6;

  typedef enum logic [3:0] {
    PH_HDR       = 4'd0,
    PH_VER_HI    = 4'd1,
    PH_VER_LO    = 4'd2,
    PH_META_LEN  = 4'd3,
    PH_META_CHAR = 4'd4,
    PH_REC_TYPE  = 4'd5,
    PH_NAME_LEN  = 4'd6,
    PH_NAME_CHAR = 4'd7,
    PH_SIZE      = 4'd8,
    PH_PAYLOAD   = 4'd9,
    PH_MARK_LEN  = 4'd10,
    PH_MARK_CHAR = 4'd11,
    PH_REJECT    = 4'd12
  } phase_t;

  typedef enum logic [3:0] {
    KIND_HEADER    = 4'd0,
    KIND_VERSION   = 4'd1,
    KIND_META_LEN  = 4'd2,
    KIND_META_CHAR = 4'd3,
    KIND_REC_TYPE  = 4'd4,
    KIND_NAME_LEN  = 4'd5,
    KIND_NAME_CHAR = 4'd6,
    KIND_SIZE      = 4'd7,
    KIND_PAYLOAD   = 4'd8,
    KIND_MARK_LEN  = 4'd9,
    KIND_MARK_CHAR = 4'd10,
    KIND_IGNORED   = 4'd11
  } kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    kind_t       kind;
    logic [2:0]  meta_field;
    logic        field_end;
    logic [31:0] size_value;
    logic        size_valid;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/archive_stream_deframer_core.sv =====
// Archive stream deframer: classifies each byte of a pack archive stream.
// Each accepted byte's result is registered; throughput 1 item per cycle while the skid entry is empty.
// A result register plus one skid entry keep input ready while a result waits.
// Synchronous active-high rst clears the phase machine and handshake state.
// Depends on asd_pkg and archive_stream_deframer_core_assert.svh.
`default_nettype none

`include "archive_stream_deframer_core_assert.svh"

module archive_stream_deframer_core
  import asd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       data_byte,
  output logic [3:0]       kind,
  output logic [2:0]       meta_field,
  output logic             field_end,
  output logic [31:0]      size_value,
  output logic             size_valid
);

  localparam logic [SIZE_WIDTH-1:0] SIZE_LIMIT = '1;
  localparam phase_t PHASE_RESET = (HEADER_SKIP == 0) ? PH_VER_HI : PH_HDR;

  // Parser state
  phase_t                phase, phase_next;
  logic [CNT_W-1:0]      byte_counter, byte_counter_next;
  logic [SIZE_WIDTH-1:0] size_acc, size_acc_next;
  logic [2:0]            field_index, field_index_next;
  logic [7:0]            version_high, version_high_next;

  // Output register and skid entry
  result_t out_reg, skid_reg;
  logic    skid_valid;
  result_t res;

  logic in_accept, out_take;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  cnt_last;
  logic [CNT_W-1:0]      byte_ext;
  logic [SIZE_WIDTH-1:0] size_shift;
  logic                  size_sat;

  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;

  assign cnt_inc    = byte_counter + CNT_W'(1);
  assign cnt_last   = (byte_counter <= CNT_W'(1));
  assign byte_ext   = CNT_W'(byte_in);
  assign size_sat   = (size_acc[SIZE_WIDTH-1 -: 7] != 7'd0);
  assign size_shift = {size_acc[SIZE_WIDTH-8:0], byte_in[6:0]};

  // Next state and result for the byte at the input
  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    size_acc_next     = size_acc;
    field_index_next  = field_index;
    version_high_next = version_high;
    res.data_byte     = byte_in;
    res.kind          = KIND_IGNORED;
    res.meta_field    = 3'd0;
    res.field_end     = 1'b0;
    res.size_value    = 32'd0;
    res.size_valid    = 1'b0;

    case (phase)
      PH_HDR: begin
        res.kind = KIND_HEADER;
        if (cnt_inc >= CNT_W'(HEADER_SKIP)) begin
          byte_counter_next = '0;
          phase_next        = PH_VER_HI;
        end else begin
          byte_counter_next = cnt_inc;
        end
      end
      PH_VER_HI: begin
        res.kind          = KIND_VERSION;
        version_high_next = byte_in;
        phase_next        = PH_VER_LO;
      end
      PH_VER_LO: begin
        res.kind = KIND_VERSION;
        if (version_high == 8'd0 && byte_in == 8'd1) begin
          phase_next = PH_REC_TYPE;
        end else if (version_high == 8'd0 && byte_in == 8'd2) begin
          field_index_next = 3'd0;
          phase_next       = PH_META_LEN;
        end else begin
          phase_next = PH_REJECT;
        end
      end
      PH_META_LEN: begin
        res.kind       = KIND_META_LEN;
        res.meta_field = field_index;
        if (byte_in == 8'd0) begin
          res.field_end = 1'b1;
          if (field_index >= META_LAST) begin
            field_index_next = 3'd0;
            phase_next       = PH_REC_TYPE;
          end else begin
            field_index_next = field_index + 3'd1;
            phase_next       = PH_META_LEN;
          end
        end else begin
          byte_counter_next = byte_ext;
          phase_next        = PH_META_CHAR;
        end
      end
      PH_META_CHAR: begin
        res.kind       = KIND_META_CHAR;
        res.meta_field = field_index;
        if (cnt_last) begin
          byte_counter_next = '0;
          res.field_end     = 1'b1;
          if (field_index >= META_LAST) begin
            field_index_next = 3'd0;
            phase_next       = PH_REC_TYPE;
          end else begin
            field_index_next = field_index + 3'd1;
            phase_next       = PH_META_LEN;
          end
        end else begin
          byte_counter_next = byte_counter - CNT_W'(1);
        end
      end
      PH_REC_TYPE: begin
        if (byte_in == REC_FILE) begin
          res.kind   = KIND_REC_TYPE;
          phase_next = PH_NAME_LEN;
        end else if (byte_in == REC_MARKER) begin
          res.kind   = KIND_REC_TYPE;
          phase_next = PH_MARK_LEN;
        end
      end
      PH_NAME_LEN: begin
        res.kind      = KIND_NAME_LEN;
        size_acc_next = '0;
        if (byte_in == 8'd0) begin
          res.field_end = 1'b1;
          phase_next    = PH_SIZE;
        end else begin
          byte_counter_next = byte_ext;
          phase_next        = PH_NAME_CHAR;
        end
      end
      PH_NAME_CHAR: begin
        res.kind = KIND_NAME_CHAR;
        if (cnt_last) begin
          byte_counter_next = '0;
          res.field_end     = 1'b1;
          size_acc_next     = '0;
          phase_next        = PH_SIZE;
        end else begin
          byte_counter_next = byte_counter - CNT_W'(1);
        end
      end
      PH_SIZE: begin
        // base-128 digit, big-endian, saturating
        res.kind      = KIND_SIZE;
        size_acc_next = size_sat ? SIZE_LIMIT : size_shift;
        if (!byte_in[7]) begin
          res.size_valid = 1'b1;
          res.field_end  = 1'b1;
          res.size_value = 32'(size_acc_next);
          if (size_acc_next == '0) begin
            phase_next = PH_REC_TYPE;
          end else begin
            byte_counter_next = CNT_W'(size_acc_next);
            phase_next        = PH_PAYLOAD;
          end
          size_acc_next = '0;
        end
      end
      PH_PAYLOAD: begin
        res.kind = KIND_PAYLOAD;
        if (cnt_last) begin
          byte_counter_next = '0;
          res.field_end     = 1'b1;
          phase_next        = PH_REC_TYPE;
        end else begin
          byte_counter_next = byte_counter - CNT_W'(1);
        end
      end
      PH_MARK_LEN: begin
        res.kind = KIND_MARK_LEN;
        if (byte_in == 8'd0) begin
          res.field_end = 1'b1;
          phase_next    = PH_REC_TYPE;
        end else begin
          byte_counter_next = byte_ext;
          phase_next        = PH_MARK_CHAR;
        end
      end
      PH_MARK_CHAR: begin
        res.kind = KIND_MARK_CHAR;
        if (cnt_last) begin
          byte_counter_next = '0;
          res.field_end     = 1'b1;
          phase_next        = PH_REC_TYPE;
        end else begin
          byte_counter_next = byte_counter - CNT_W'(1);
        end
      end
      default: begin
        res.kind   = KIND_IGNORED;
        phase_next = PH_REJECT;
      end
    endcase
  end

  // Parser state registers, advanced on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_RESET;
      byte_counter <= '0;
      size_acc     <= '0;
      field_index  <= 3'd0;
      version_high <= 8'd0;
    end else if (in_accept) begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      size_acc     <= size_acc_next;
      field_index  <= field_index_next;
      version_high <= version_high_next;
    end
  end

  // Output and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      out_valid  <= skid_valid || in_accept;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_accept) begin
        out_reg <= res;
      end
    end else if (in_accept) begin
      skid_reg <= res;
    end
  end

  assign data_byte  = out_reg.data_byte;
  assign kind       = out_reg.kind;
  assign meta_field = out_reg.meta_field;
  assign field_end  = out_reg.field_end;
  assign size_value = out_reg.size_value;
  assign size_valid = out_reg.size_valid;

  // Checks
  `ASD_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
    "skid entry held without a result in the output register")
  `ASD_ASSERT_NOW(a_skid_fill, $rose(skid_valid), $past(out_valid && !out_ready),
    "skid entry filled while the output register was free")
  `ASD_ASSERT_NOW(a_size_kind, out_valid && size_valid,
    out_reg.kind == KIND_SIZE && field_end,
    "size_valid on a result that is not a final size byte")
  `ASD_ASSERT_NEXT(a_reject_sticky, phase == PH_REJECT, phase == PH_REJECT,
    "parser left the reject phase")
  `ASD_ASSERT_NOW(a_meta_range,
    out_valid && (out_reg.kind == KIND_META_LEN || out_reg.kind == KIND_META_CHAR),
    meta_field <= META_LAST,
    "metadata index out of range")

endmodule

`default_nettype wire

// ===== bench/tb_archive_stream_deframer_core.sv =====
// Testbench for archive_stream_deframer_core: streams a version 2 archive
// through the block and checks every classified byte against its own predictor.
// Depends on asd_pkg and the archive_stream_deframer_core RTL.

module tb_archive_stream_deframer_core
  import asd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  VERSION_HI   = 8'h00;
  localparam logic [7:0]  VERSION_LO   = 8'h02;
  localparam logic [7:0]  SIZE_MORE    = 8'h80;
  localparam logic [63:0] SIZE_MAX     =
    (SIZE_WIDTH >= 64) ? '1 : ((64'd1 << SIZE_WIDTH) - 64'd1);
  localparam int          STALL_PCT    = 9;
  localparam int          TOTAL_BYTES  = 1550;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  data_byte;
  logic [3:0]  kind;
  logic [2:0]  meta_field;
  logic        field_end;
  logic [31:0] size_value;
  logic        size_valid;

  // predictor state
  phase_t      ph;
  logic [63:0] remaining;
  logic [63:0] size_acc;
  logic [2:0]  meta_idx;
  logic [7:0]  ver_hi;

  result_t     predicted_classes[$];
  int          bytes_sent = 0;
  int          errors = 0;
  bit          calm = 1'b0;

  archive_stream_deframer_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .kind       (kind),
    .meta_field (meta_field),
    .field_end  (field_end),
    .size_value (size_value),
    .size_valid (size_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Move to the next metadata string, or on to the records after the last one
  function automatic void advance_meta();
    if (meta_idx >= META_LAST) begin
      meta_idx = '0;
      ph = PH_REC_TYPE;
    end else begin
      meta_idx = meta_idx + 3'd1;
      ph = PH_META_LEN;
    end
  endfunction

  // Classify one accepted byte and advance the predicted phase machine
  function automatic result_t classify_byte(logic [7:0] b);
    result_t r;
    r = '0;
    r.data_byte = b;
    r.kind = KIND_IGNORED;
    case (ph)
      PH_HDR: begin
        r.kind = KIND_HEADER;
        remaining = remaining + 64'd1;
        if (remaining >= HEADER_SKIP) begin
          remaining = '0;
          ph = PH_VER_HI;
        end
      end
      PH_VER_HI: begin
        r.kind = KIND_VERSION;
        ver_hi = b;
        ph = PH_VER_LO;
      end
      PH_VER_LO: begin
        r.kind = KIND_VERSION;
        if ({ver_hi, b} == 16'd1) begin
          ph = PH_REC_TYPE;
        end else if ({ver_hi, b} == 16'd2) begin
          meta_idx = '0;
          ph = PH_META_LEN;
        end else begin
          ph = PH_REJECT;
        end
      end
      PH_META_LEN: begin
        r.kind = KIND_META_LEN;
        r.meta_field = meta_idx;
        if (b == 8'h00) begin
          r.field_end = 1'b1;
          advance_meta();
        end else begin
          remaining = 64'(b);
          ph = PH_META_CHAR;
        end
      end
      PH_META_CHAR: begin
        r.kind = KIND_META_CHAR;
        r.meta_field = meta_idx;
        if (remaining <= 64'd1) begin
          remaining = '0;
          r.field_end = 1'b1;
          advance_meta();
        end else begin
          remaining = remaining - 64'd1;
        end
      end
      PH_REC_TYPE: begin
        if (b == REC_FILE) begin
          r.kind = KIND_REC_TYPE;
          ph = PH_NAME_LEN;
        end else if (b == REC_MARKER) begin
          r.kind = KIND_REC_TYPE;
          ph = PH_MARK_LEN;
        end
      end
      PH_NAME_LEN: begin
        r.kind = KIND_NAME_LEN;
        size_acc = '0;
        if (b == 8'h00) begin
          r.field_end = 1'b1;
          ph = PH_SIZE;
        end else begin
          remaining = 64'(b);
          ph = PH_NAME_CHAR;
        end
      end
      PH_NAME_CHAR: begin
        r.kind = KIND_NAME_CHAR;
        if (remaining <= 64'd1) begin
          remaining = '0;
          r.field_end = 1'b1;
          size_acc = '0;
          ph = PH_SIZE;
        end else begin
          remaining = remaining - 64'd1;
        end
      end
      PH_SIZE: begin
        r.kind = KIND_SIZE;
        // saturate once another 7 bits would no longer fit
        if (size_acc > (SIZE_MAX >> 7)) begin
          size_acc = SIZE_MAX;
        end else begin
          size_acc = (size_acc << 7) | 64'(b[6:0]);
          if (size_acc > SIZE_MAX) size_acc = SIZE_MAX;
        end
        if (!b[7]) begin
          r.size_valid = 1'b1;
          r.field_end = 1'b1;
          r.size_value = size_acc[31:0];
          if (size_acc == '0) begin
            ph = PH_REC_TYPE;
          end else begin
            remaining = size_acc;
            ph = PH_PAYLOAD;
          end
          size_acc = '0;
        end
      end
      PH_PAYLOAD: begin
        r.kind = KIND_PAYLOAD;
        if (remaining <= 64'd1) begin
          remaining = '0;
          r.field_end = 1'b1;
          ph = PH_REC_TYPE;
        end else begin
          remaining = remaining - 64'd1;
        end
      end
      PH_MARK_LEN: begin
        r.kind = KIND_MARK_LEN;
        if (b == 8'h00) begin
          r.field_end = 1'b1;
          ph = PH_REC_TYPE;
        end else begin
          remaining = 64'(b);
          ph = PH_MARK_CHAR;
        end
      end
      PH_MARK_CHAR: begin
        r.kind = KIND_MARK_CHAR;
        if (remaining <= 64'd1) begin
          remaining = '0;
          r.field_end = 1'b1;
          ph = PH_REC_TYPE;
        end else begin
          remaining = remaining - 64'd1;
        end
      end
      default: begin
        r.kind = KIND_IGNORED;
        ph = PH_REJECT;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Result side: compare each accepted item, then pick the next ready
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (predicted_classes.size() == 0) begin
          $error("unexpected result item, data_byte %0h kind %0d", data_byte, kind);
          errors++;
        end else begin
          want = predicted_classes.pop_front();
          check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("meta_field", 32'(want.meta_field), 32'(meta_field));
          check_field("field_end", 32'(want.field_end), 32'(field_end));
          check_field("size_value", want.size_value, size_value);
          check_field("size_valid", 32'(want.size_valid), 32'(size_valid));
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Offer one byte, with a random gap first, and predict it once accepted
  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_classes.push_back(classify_byte(b));
    bytes_sent++;
  endtask

  // Length byte followed by that many random characters
  task automatic send_string(int len);
    send_byte(8'(len));
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Big-endian base-128 size, optionally led by redundant zero groups
  task automatic send_size(logic [31:0] v, int pad);
    int groups;
    groups = 1;
    while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
    repeat (pad) send_byte(SIZE_MORE);
    for (int i = groups - 1; i >= 0; i--) begin
      send_byte({i != 0, 7'(v >> (7 * i))});
    end
  endtask

  task automatic send_file(int name_len, int size, int pad);
    send_byte(REC_FILE);
    send_string(name_len);
    send_size(32'(size), pad);
    repeat (size) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_marker(int len);
    send_byte(REC_MARKER);
    send_string(len);
  endtask

  // Mostly well-formed records; some unknown type bytes as noise
  task automatic random_record();
    int pick;
    int len;
    int size;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 8);
    if (pick < 55) begin
      size = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 400) : $urandom_range(0, 16);
      send_file(len, size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    end else if (pick < 80) begin
      send_marker(len);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(1, 254)));
    end
  endtask

  task automatic wait_for_results(int max_cycles);
    int spins;
    spins = 0;
    while (predicted_classes.size() != 0 && spins < max_cycles) begin
      @(posedge clk);
      spins++;
    end
  endtask

  task automatic test_header_and_version();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    repeat (HEADER_SKIP - 4) send_byte(8'($urandom_range(0, 255)));
    send_byte(VERSION_HI);
    send_byte(VERSION_LO);
  endtask

  // Seven strings: empty ones, single characters and a longer one
  task automatic test_metadata();
    send_string(0);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_string(0);
    send_string(2);
    send_string(0);
    send_string(0);
    send_byte(8'h01);
    send_byte(8'h00);
  endtask

  task automatic test_record_types();
    send_file(0, 0, 0);        // empty name and empty payload
    send_byte(8'h01);          // unknown type bytes
    send_byte(8'hFE);
    send_marker(0);
    send_marker(2);
    send_file(1, 3, 2);        // size led by zero groups
    send_file(2, 129, 0);      // two-byte size
  endtask

  task automatic test_random_records(int target);
    while (bytes_sent < target) random_record();
  endtask

  // Sender holds off until the block has returned every result
  task automatic test_pause_until_drained();
    repeat (3) random_record();
    in_valid <= 1'b0;
    wait_for_results(100000);
    repeat (3) random_record();
  endtask

  task automatic test_steady_stream(int target);
    calm = 1'b1;
    while (bytes_sent < target) random_record();
    calm = 1'b0;
  endtask

  // Oversized size saturates; the payload then never ends, so this runs last
  task automatic test_size_saturation();
    send_byte(REC_FILE);
    send_string(0);
    repeat (5) send_byte(8'hFF);
    send_byte(8'h7F);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    ph        = (HEADER_SKIP == 0) ? PH_VER_HI : PH_HDR;
    remaining = '0;
    size_acc  = '0;
    meta_idx  = '0;
    ver_hi    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header_and_version();
    test_metadata();
    test_record_types();
    test_random_records(800);
    test_pause_until_drained();
    test_random_records(1150);
    test_steady_stream(TOTAL_BYTES - 15);
    test_size_saturation();

    in_valid <= 1'b0;
    wait_for_results(100000);
    repeat (20) @(posedge clk);
    if (predicted_classes.size() != 0) begin
      $error("%0d result items never arrived", predicted_classes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[archive_stream_deframer_core] OK");
    end else begin
      $display("[archive_stream_deframer_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[archive_stream_deframer_core] ERROR");
    $finish;
  end

endmodule

// ===== archive_stream_deframer_core.f =====
+incdir+rtl
rtl/asd_pkg.sv
rtl/archive_stream_deframer_core.sv
bench/tb_archive_stream_deframer_core.sv
